// ===== src/dts_pkg.sv =====
package dts_pkg;

  localparam int FreqW = 28;
  localparam int WeightW = 31;
  localparam int DigitW = 4;
  localparam int ProdW = WeightW + DigitW;
  localparam int QueueDepth = 2;

  localparam logic [WeightW-1:0] WeightReset = 31'd343597383;
  localparam logic [31:0] Recip10 = 32'hCCCC_CCCD;
  localparam int Recip10Shift = 35;

  typedef struct packed {
    logic signed [FreqW-1:0] frequency_hz;
    logic                    target;
  } dts_in_t;

  typedef struct packed {
    logic serial_bit;
    logic last_bit;
    logic strobe_target;
  } dts_out_t;

endpackage

// ===== src/dts_front.sv =====
module dts_front import dts_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int DECIMAL_DIGITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  dts_in_t              in_i,
  output logic                 busy_o,
  input  logic                 cfg_we_i,
  input  logic [WeightW-1:0]   cfg_wdata_i,
  input  logic                 full_i,
  output logic                 push_o,
  output logic [WORD_BITS-1:0] word_o,
  output logic                 target_o
);

  localparam int CntW = $clog2(DECIMAL_DIGITS + 1);
  localparam int AccW = (WORD_BITS > ProdW) ? WORD_BITS : ProdW;

  typedef enum logic [3:0] {
    FIdle  = 4'b0001,
    FDigit = 4'b0010,
    FAccum = 4'b0100,
    FDone  = 4'b1000
  } front_state_e;

  function automatic logic [31:0] div10(input logic [31:0] x);
    logic [63:0] p;
    p = 64'(x) * 64'(Recip10);
    return 32'(p >> Recip10Shift);
  endfunction

  front_state_e state_q, state_d;
  logic [WeightW-1:0] cfg_weight_q;
  logic [FreqW-1:0] mag_q, mag_d;
  logic [WeightW-1:0] weight_q, weight_d;
  logic [WORD_BITS-1:0] acc_q, acc_d;
  logic [DigitW-1:0] dig_q [DECIMAL_DIGITS];
  logic [DigitW-1:0] dig_d [DECIMAL_DIGITS];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic neg_q, neg_d;
  logic tgt_q, tgt_d;

  logic accept;
  logic last_step;
  logic [31:0] div_in;
  logic [31:0] div_q;
  logic [31:0] div_rem;
  logic [ProdW-1:0] prod;
  logic [AccW-1:0] sum;

  assign busy_o = !((state_q == FIdle) || ((state_q == FDone) && !full_i));
  assign accept = start_i && !busy_o;
  assign push_o = (state_q == FDone) && !full_i;
  assign word_o = acc_q;
  assign target_o = tgt_q;
  assign last_step = (cnt_q == CntW'(DECIMAL_DIGITS - 1));

  assign div_in = (state_q == FDigit) ? 32'(mag_q) : 32'(weight_q);
  assign div_q = div10(div_in);
  assign div_rem = div_in - (div_q << 3) - (div_q << 1);
  assign prod = ProdW'(weight_q) * ProdW'(dig_q[0]);
  assign sum = neg_q ? (AccW'(acc_q) - AccW'(prod)) : (AccW'(acc_q) + AccW'(prod));

  always_comb begin
    state_d = state_q;
    mag_d = mag_q;
    weight_d = weight_q;
    acc_d = acc_q;
    dig_d = dig_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    tgt_d = tgt_q;
    unique case (state_q)
      FIdle: begin
      end
      FDigit: begin
        for (int i = 1; i < DECIMAL_DIGITS; i++) begin
          dig_d[i] = dig_q[i-1];
        end
        dig_d[0] = div_rem[DigitW-1:0];
        mag_d = div_q[FreqW-1:0];
        cnt_d = cnt_q + CntW'(1);
        if (last_step) begin
          cnt_d = '0;
          state_d = FAccum;
        end
      end
      FAccum: begin
        acc_d = sum[WORD_BITS-1:0];
        weight_d = div_q[WeightW-1:0];
        for (int i = 0; i < DECIMAL_DIGITS - 1; i++) begin
          dig_d[i] = dig_q[i+1];
        end
        dig_d[DECIMAL_DIGITS-1] = '0;
        cnt_d = cnt_q + CntW'(1);
        if (last_step) begin
          cnt_d = '0;
          state_d = FDone;
        end
      end
      FDone: begin
        if (!full_i) begin
          state_d = FIdle;
        end
      end
      default: begin
        state_d = FIdle;
      end
    endcase
    if (accept) begin
      mag_d = in_i.frequency_hz[FreqW-1] ? FreqW'(-in_i.frequency_hz) : in_i.frequency_hz;
      neg_d = in_i.frequency_hz[FreqW-1];
      tgt_d = in_i.target;
      weight_d = cfg_weight_q;
      acc_d = '0;
      cnt_d = '0;
      state_d = FDigit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIdle;
      cfg_weight_q <= WeightReset;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        cfg_weight_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    weight_q <= weight_d;
    acc_q <= acc_d;
    dig_q <= dig_d;
    neg_q <= neg_d;
    tgt_q <= tgt_d;
  end

endmodule

// ===== src/dts_queue.sv =====
module dts_queue import dts_pkg::*; #(
  parameter int DATA_W = 33
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CountW = $clog2(QueueDepth + 1);

  logic [DATA_W-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CountW-1:0] count_q;
  logic do_push, do_pop;

  assign full_o = (count_q == CountW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign data_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CountW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/dts_back.sv =====
module dts_back import dts_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAME_BITS = 40
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  logic [WORD_BITS-1:0] word_i,
  input  logic                 target_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  output dts_out_t             out_o
);

  localparam int CntW = $clog2(FRAME_BITS);

  logic active_q;
  logic [CntW-1:0] cnt_q;
  logic [WORD_BITS-1:0] sh_q;
  logic tgt_q;
  logic last;
  logic load;

  assign last = active_q && (cnt_q == CntW'(FRAME_BITS - 1));
  assign load = q_valid_i && (!active_q || last);
  assign pop_o = load;

  assign out_valid_o = active_q;
  assign out_o.serial_bit = active_q && (32'(cnt_q) < WORD_BITS) && sh_q[0];
  assign out_o.last_bit = last;
  assign out_o.strobe_target = tgt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q <= '0;
    end else if (load) begin
      active_q <= 1'b1;
      cnt_q <= '0;
    end else if (active_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (last) begin
        active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sh_q <= word_i;
      tgt_q <= target_i;
    end else if (active_q) begin
      sh_q <= sh_q >> 1;
    end
  end

endmodule

// ===== src/dds_tuning_word_serial_loader.sv =====
// Serial loader for a DDS frequency tuning word.
// A transaction on the input side is accepted at a clock edge where start_i is
// high and busy_o is low; it carries a signed frequency in hertz and the target
// synthesizer. The decimal digits are split off one per cycle through a shared
// divide-by-ten unit, then weighted and summed one per cycle; the finished word
// is pushed into the queue from a done state that waits while the queue is full.
// Finished words wait in a two-entry queue. The serializer sends FRAME_BITS
// result transactions, one per cycle, each marked by out_valid_o: the word
// LSB first, then zero bits, with last_bit set on the final one.
// Frames follow each other without a gap while the queue holds a word, so the
// sustained throughput is set by the serializer.
// The receiver cannot stall; each result is valid for exactly one cycle.
// The user must write the weight register (cfg_we_i, cfg_wdata_i) only while idle;
// the block itself does not enforce this.
// Reset empties the queue, stops any frame and restores the default weight.
module dds_tuning_word_serial_loader import dts_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAME_BITS = 40,
  parameter int DECIMAL_DIGITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  dts_in_t            in_i,
  output logic               busy_o,
  input  logic               cfg_we_i,
  input  logic [WeightW-1:0] cfg_wdata_i,
  output logic               out_valid_o,
  output dts_out_t           out_o
);

  logic full;
  logic push;
  logic [WORD_BITS-1:0] front_word;
  logic front_target;
  logic pop;
  logic q_valid;
  logic [WORD_BITS:0] q_data;

  dts_front #(
    .WORD_BITS      (WORD_BITS),
    .DECIMAL_DIGITS (DECIMAL_DIGITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .in_i        (in_i),
    .busy_o      (busy_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .full_i      (full),
    .push_o      (push),
    .word_o      (front_word),
    .target_o    (front_target)
  );

  dts_queue #(
    .DATA_W (WORD_BITS + 1)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({front_target, front_word}),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  dts_back #(
    .WORD_BITS  (WORD_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .word_i      (q_data[WORD_BITS-1:0]),
    .target_i    (q_data[WORD_BITS]),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule
